### rtl/core/modexp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Word size, sequencer states and the shared shift-add-reduce step.
// ----------------------------------------------------------------------------
package modexp_pkg;

    localparam int WORD_BITS = 32;
    localparam int CNT_BITS  = $clog2(WORD_BITS);

    typedef logic [WORD_BITS-1:0] word_t;
    typedef logic [CNT_BITS-1:0]  cnt_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_SQUARE,
        ST_MULT,
        ST_FINISH
    } state_t;

    // One step of interleaved modular multiplication:
    // (2*acc + (take ? addend : 0)) mod m, with acc and addend below m.
    // A modulus of zero stands for 2^WORD_BITS, so the sum just wraps.
    function automatic word_t mod_step(input word_t acc, input word_t addend,
                                       input logic take, input word_t m);
        logic [WORD_BITS+1:0] sum;
        logic [WORD_BITS+2:0] diff1;
        logic [WORD_BITS+2:0] diff2;
        word_t                res;
        sum   = {1'b0, acc, 1'b0} + (take ? {2'b00, addend} : '0);
        diff1 = {1'b0, sum} - {3'b000, m};
        diff2 = {1'b0, sum} - {2'b00, m, 1'b0};
        if (m == '0) begin
            res = sum[WORD_BITS-1:0];
        end else if (!diff2[WORD_BITS+2]) begin
            res = diff2[WORD_BITS-1:0];
        end else if (!diff1[WORD_BITS+2]) begin
            res = diff1[WORD_BITS-1:0];
        end else begin
            res = sum[WORD_BITS-1:0];
        end
        return res;
    endfunction

endpackage

### rtl/core/modular_exponentiation_unit.sv
`timescale 1ns / 1ps
// Work: a base reduction, then a square for each of the 32 exponent bits and a
//   multiply for each set bit, on one shift-add-reduce unit, one multiplier bit a cycle.
// Throughput: one transaction at a time; a zero exponent goes straight to finish.
// A finished result waits in the output register while the next one is taken.
// Reset (aresetn low, synchronous): sequencer idle, no result held, modulus 2.
// ----------------------------------------------------------------------------
// Modular exponentiation unit
// Computes base^exponent mod modulus by left-to-right square-and-multiply,
// each product formed bit-serially on one shared modular add/reduce step.
// ----------------------------------------------------------------------------
module modular_exponentiation_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration: modulus
    input  logic                                cfg_wen,
    input  modexp_pkg::word_t                   cfg_wdata,
    // input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [2*modexp_pkg::WORD_BITS-1:0]  s_tdata,    // [31:0] base, [63:32] exponent
    // result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output modexp_pkg::word_t                   m_tdata,    // [31:0] key_value
    output logic                                m_tuser     // [0] exponent_in_range
);

    localparam int W = modexp_pkg::WORD_BITS;
    localparam modexp_pkg::cnt_t CNT_LAST = modexp_pkg::cnt_t'(W - 1);

    modexp_pkg::state_t state_reg, state_next;

    modexp_pkg::word_t mod_reg, mod_next;
    modexp_pkg::word_t base_reg, base_next;
    modexp_pkg::word_t exp_reg, exp_next;
    modexp_pkg::word_t acc_reg, acc_next;
    modexp_pkg::word_t mul_a_reg, mul_a_next;
    modexp_pkg::word_t mul_b_reg, mul_b_next;
    modexp_pkg::word_t res_reg, res_next;
    logic              range_reg, range_next;
    modexp_pkg::cnt_t  step_cnt_reg, step_cnt_next;
    modexp_pkg::cnt_t  bit_cnt_reg, bit_cnt_next;
    logic              out_valid_reg, out_valid_next;
    modexp_pkg::word_t out_data_reg, out_data_next;
    logic              out_user_reg, out_user_next;

    logic              in_accept;
    logic              out_free;
    logic              out_load;
    logic              step_last;
    logic              bit_last;
    modexp_pkg::word_t unit_addend;
    logic              unit_take;
    modexp_pkg::word_t unit_out;
    modexp_pkg::word_t res_init;
    modexp_pkg::word_t in_base;
    modexp_pkg::word_t in_exp;

    assign in_base   = s_tdata[W-1:0];
    assign in_exp    = s_tdata[2*W-1:W];
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;
    assign step_last = (step_cnt_reg == CNT_LAST);
    assign bit_last  = (bit_cnt_reg == CNT_LAST);
    assign res_init  = (mod_reg == modexp_pkg::word_t'(1)) ? '0 : modexp_pkg::word_t'(1);

    // Shared modular step unit
    assign unit_out = modexp_pkg::mod_step(acc_reg, unit_addend, unit_take, mod_reg);

    // Sequencer: next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            modexp_pkg::ST_IDLE: begin
                if (in_accept) begin
                    state_next = (in_exp == '0) ? modexp_pkg::ST_FINISH
                                                : modexp_pkg::ST_REDUCE;
                end
            end
            modexp_pkg::ST_REDUCE: begin
                if (step_last) begin
                    state_next = modexp_pkg::ST_SQUARE;
                end
            end
            modexp_pkg::ST_SQUARE: begin
                if (step_last) begin
                    if (exp_reg[W-1]) begin
                        state_next = modexp_pkg::ST_MULT;
                    end else if (bit_last) begin
                        state_next = modexp_pkg::ST_FINISH;
                    end else begin
                        state_next = modexp_pkg::ST_SQUARE;
                    end
                end
            end
            modexp_pkg::ST_MULT: begin
                if (step_last) begin
                    state_next = bit_last ? modexp_pkg::ST_FINISH : modexp_pkg::ST_SQUARE;
                end
            end
            modexp_pkg::ST_FINISH: begin
                if (out_free) begin
                    state_next = modexp_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = modexp_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer: outputs and operand select
    always_comb begin
        s_tready    = 1'b0;
        out_load    = 1'b0;
        unit_addend = mul_a_reg;
        unit_take   = mul_b_reg[W-1];
        case (state_reg)
            modexp_pkg::ST_IDLE: begin
                s_tready = 1'b1;
            end
            modexp_pkg::ST_REDUCE: begin
                // shift base bits in one at a time: remainder by the modulus
                unit_addend = modexp_pkg::word_t'(1);
                unit_take   = base_reg[W-1];
            end
            modexp_pkg::ST_FINISH: begin
                out_load = out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    // Datapath next values
    always_comb begin
        mod_next       = mod_reg;
        base_next      = base_reg;
        exp_next       = exp_reg;
        acc_next       = acc_reg;
        mul_a_next     = mul_a_reg;
        mul_b_next     = mul_b_reg;
        res_next       = res_reg;
        range_next     = range_reg;
        step_cnt_next  = step_cnt_reg;
        bit_cnt_next   = bit_cnt_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;

        if (cfg_wen) begin
            mod_next = cfg_wdata;
        end

        case (state_reg)
            modexp_pkg::ST_IDLE: begin
                if (in_accept) begin
                    base_next     = in_base;
                    exp_next      = in_exp;
                    range_next    = (in_exp != '0) && (mod_reg != '0) && (in_exp < mod_reg);
                    acc_next      = '0;
                    step_cnt_next = '0;
                    bit_cnt_next  = '0;
                    res_next      = modexp_pkg::word_t'(1);
                end
            end
            modexp_pkg::ST_REDUCE: begin
                acc_next      = unit_out;
                base_next     = base_reg << 1;
                step_cnt_next = step_cnt_reg + 1'b1;
                if (step_last) begin
                    base_next  = unit_out;
                    acc_next   = '0;
                    res_next   = res_init;
                    mul_a_next = res_init;
                    mul_b_next = res_init;
                end
            end
            modexp_pkg::ST_SQUARE, modexp_pkg::ST_MULT: begin
                acc_next      = unit_out;
                mul_b_next    = mul_b_reg << 1;
                step_cnt_next = step_cnt_reg + 1'b1;
                if (step_last) begin
                    res_next = unit_out;
                    acc_next = '0;
                    if ((state_reg == modexp_pkg::ST_SQUARE) && exp_reg[W-1]) begin
                        // multiply by the reduced base for a set exponent bit
                        mul_a_next = base_reg;
                        mul_b_next = unit_out;
                    end else begin
                        // advance to the next exponent bit; square again unless it was the last
                        exp_next     = exp_reg << 1;
                        bit_cnt_next = bit_cnt_reg + 1'b1;
                        mul_a_next   = unit_out;
                        mul_b_next   = unit_out;
                    end
                end
            end
            default: begin
                acc_next = acc_reg;
            end
        endcase

        // Drop a delivered result, then load a new one
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end
        if (out_load) begin
            out_valid_next = 1'b1;
            out_data_next  = res_reg;
            out_user_next  = range_reg;
        end
    end

    // Registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= modexp_pkg::ST_IDLE;
            mod_reg       <= modexp_pkg::word_t'(2);
            step_cnt_reg  <= '0;
            bit_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            mod_reg       <= mod_next;
            step_cnt_reg  <= step_cnt_next;
            bit_cnt_reg   <= bit_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        base_reg     <= base_next;
        exp_reg      <= exp_next;
        acc_reg      <= acc_next;
        mul_a_reg    <= mul_a_next;
        mul_b_reg    <= mul_b_next;
        res_reg      <= res_next;
        range_reg    <= range_next;
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

`ifndef SYNTHESIS
    // Partial product stays reduced below a nonzero modulus
    assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == modexp_pkg::ST_SQUARE) || (state_reg == modexp_pkg::ST_MULT))
        && (mod_reg != '0) |-> (acc_reg < mod_reg))
    else $error("modexp: accumulator not reduced");

    // An in-range exponent yields a result below the modulus
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> (m_tdata < mod_reg))
    else $error("modexp: result not below modulus");

    // A nonzero exponent starts with the base reduction
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept && (in_exp != '0) |=> (state_reg == modexp_pkg::ST_REDUCE) && !s_tready)
    else $error("modexp: reduction not started");

    // Step counter sits at zero in the finish state
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == modexp_pkg::ST_FINISH) |-> (step_cnt_reg == '0))
    else $error("modexp: step counter misaligned");
`endif

endmodule
